@@ rtl/lj_pkg.sv @@
// shared widths, constants and types of the lennard-jones pair force pipeline
package lj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_BITS  = 24;
    localparam int CFG_BITS  = 32;
    localparam int IDX_BITS  = 3;

    localparam int D_BITS    = POS_BITS + 2;
    localparam int AD_BITS   = POS_BITS + 1;
    localparam int SQ_BITS   = 2 * AD_BITS;
    localparam int R2F_BITS  = SQ_BITS + 2;
    localparam int R2_BITS   = CFG_BITS + FRAC_BITS;
    localparam int R2Q_BITS  = CFG_BITS;
    localparam int DIV_BITS  = 3 * FRAC_BITS + 1;
    localparam int SQRT_BITS = (R2_BITS + 1) / 2;
    localparam int SV_BITS   = 2 * SQRT_BITS;
    localparam int SREM_BITS = SQRT_BITS + 4;

    localparam int MW = 64;
    localparam int MH = MW / 2;

    localparam int FO_BITS = 40;
    localparam int VO_BITS = 48;

    localparam logic [MW-1:0] CAP = (MW'(1) << 62) - MW'(1);
    localparam logic [MW-1:0] ONE = MW'(1) << FRAC_BITS;

    localparam logic [POS_BITS-1:0] BOX_RST    = POS_BITS'(655360);
    localparam logic [CFG_BITS-1:0] SIGMA6_RST = CFG_BITS'(65536);
    localparam logic [CFG_BITS-1:0] EPS24_RST  = CFG_BITS'(1572864);
    localparam logic [CFG_BITS-1:0] EPS4_RST   = CFG_BITS'(262144);
    localparam logic [CFG_BITS-1:0] CUT_RST    = CFG_BITS'(409600);
    localparam logic signed [CFG_BITS-1:0] ECUT_RST = -CFG_BITS'(1069);

    typedef enum logic [IDX_BITS-1:0] {
        CFG_BOX_X,
        CFG_BOX_Y,
        CFG_BOX_Z,
        CFG_SIGMA6,
        CFG_EPS24,
        CFG_EPS4,
        CFG_CUTOFF_SQ,
        CFG_E_CUT
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][AD_BITS-1:0] ad;
        logic [2:0]              neg;
        logic                    in_cut;
        logic                    coinc;
        logic [R2Q_BITS-1:0]     r2q;
    } t_side;

    typedef struct packed {
        logic               vld;
        t_side              side;
        logic [R2_BITS-1:0] r2;
    } t_geo;

endpackage

@@ rtl/lj_mulq.sv @@
// two-stage saturating fixed-point multiplier built from 32x32 partial products
module lj_mulq import lj_pkg::*; (
    input  logic          i_clk,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic [MW-1:0] o_p
);

    logic [MW-1:0]   r_ll;
    logic [MW-1:0]   r_lh;
    logic [MW-1:0]   r_hl;
    logic            r_hh;
    logic [MW-1:0]   r_p;
    logic [MW-1:0]   n_p;
    logic [MW+1:0]   w_mid;
    logic [MW-1:0]   w_prod;
    logic            w_ovf;

    always_ff @(posedge i_clk) begin
        r_ll <= i_a[MH-1:0] * i_b[MH-1:0];
        r_lh <= i_a[MH-1:0] * i_b[MW-1:MH];
        r_hl <= i_a[MW-1:MH] * i_b[MH-1:0];
        r_hh <= (|i_a[MW-1:MH]) && (|i_b[MW-1:MH]);
        r_p  <= n_p;
    end

    // product reaching 2^64 saturates, as does anything above the cap
    always_comb begin
        w_mid  = (MW+2)'(r_lh) + (MW+2)'(r_hl) + (MW+2)'(r_ll[MW-1:MH]);
        w_ovf  = r_hh || (|w_mid[MW+1:MH]);
        w_prod = {w_mid[MH-1:0], r_ll[MH-1:0]};
        n_p    = w_ovf ? CAP : (w_prod >> FRAC_BITS);
    end

    assign o_p = r_p;

endmodule

@@ rtl/lj_geom.sv @@
// minimum-image difference, squared distance, cutoff and coincidence flags
module lj_geom import lj_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [2:0][POS_BITS-1:0] i_pos_i,
    input  logic [2:0][POS_BITS-1:0] i_pos_j,
    input  logic [2:0][POS_BITS-1:0] i_box,
    input  logic [CFG_BITS-1:0]      i_cutoff_sq,
    output t_geo                     o_geo
);

    logic [3:0]                r_v;
    logic signed [D_BITS-1:0]  r_d  [3];
    logic signed [D_BITS-1:0]  r_f  [3];
    logic signed [D_BITS-1:0]  n_f  [3];
    logic [SQ_BITS-1:0]        r_sq [3];
    logic [SQ_BITS-1:0]        n_sq [3];
    logic [2:0][AD_BITS-1:0]   r_ad;
    logic [2:0][AD_BITS-1:0]   n_ad;
    logic [2:0]                r_neg;
    t_geo                      r_geo;
    t_geo                      n_geo;
    logic [R2F_BITS-1:0]       w_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_d[k]   <= $signed({2'b00, i_pos_i[k]}) - $signed({2'b00, i_pos_j[k]});
            r_f[k]   <= n_f[k];
            r_sq[k]  <= n_sq[k];
            r_neg[k] <= r_f[k][D_BITS-1];
        end
        r_ad  <= n_ad;
        r_geo <= n_geo;
    end

    // fold each axis once by its box length
    always_comb begin
        logic signed [D_BITS:0] w2;
        logic signed [D_BITS:0] wl;
        logic signed [D_BITS:0] ws;
        for (int k = 0; k < 3; k++) begin
            w2 = {r_d[k], 1'b0};
            wl = $signed({{(D_BITS + 1 - POS_BITS){1'b0}}, i_box[k]});
            if (w2 < -wl) begin
                ws = {r_d[k][D_BITS-1], r_d[k]} + wl;
            end else if (w2 > wl) begin
                ws = {r_d[k][D_BITS-1], r_d[k]} - wl;
            end else begin
                ws = {r_d[k][D_BITS-1], r_d[k]};
            end
            n_f[k] = ws[D_BITS-1:0];
        end
    end

    always_comb begin
        logic signed [2*D_BITS-1:0] wp;
        logic signed [D_BITS-1:0]   wa;
        for (int k = 0; k < 3; k++) begin
            wp      = r_f[k] * r_f[k];
            n_sq[k] = wp[SQ_BITS-1:0];
            wa      = r_f[k][D_BITS-1] ? -r_f[k] : r_f[k];
            n_ad[k] = wa[AD_BITS-1:0];
        end
    end

    always_comb begin
        w_r2 = R2F_BITS'(r_sq[0]) + R2F_BITS'(r_sq[1]) + R2F_BITS'(r_sq[2]);
        n_geo.vld         = r_v[2];
        n_geo.side.ad     = r_ad;
        n_geo.side.neg    = r_neg;
        n_geo.side.in_cut = w_r2 < R2F_BITS'({i_cutoff_sq, {FRAC_BITS{1'b0}}});
        n_geo.side.coinc  = w_r2 == '0;
        n_geo.side.r2q    = w_r2[FRAC_BITS +: R2Q_BITS];
        n_geo.r2          = w_r2[R2_BITS-1:0];
    end

    assign o_geo = '{vld: r_v[3], side: r_geo.side, r2: r_geo.r2};

    a_coinc_axes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (r_geo.side.coinc == (r_geo.side.ad == '0)))
        else $error("coincident flag disagrees with axis distances");

endmodule

@@ rtl/lj_recip.sv @@
// pipelined restoring divider for 2^(3F)/r2 with an integer square root alongside
module lj_recip import lj_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_geo                 i_geo,
    output logic                 o_vld,
    output t_side                o_side,
    output logic [DIV_BITS-1:0]  o_inv,
    output logic [SQRT_BITS-1:0] o_root
);

    localparam int LAST = DIV_BITS - 1;
    localparam int PW   = DIV_BITS + R2_BITS + 2;
    localparam logic [PW-1:0] NUM = PW'(1) << (3 * FRAC_BITS);

    typedef struct packed {
        t_side                side;
        logic [R2_BITS-1:0]   dv;
        logic [R2_BITS-1:0]   rem;
        logic [DIV_BITS-1:0]  quo;
        logic [SREM_BITS-1:0] srem;
        logic [SQRT_BITS-1:0] root;
    } t_rst;

    logic [DIV_BITS-1:0] r_v;
    t_rst                r_st [DIV_BITS];
    t_rst                w_seed;
    t_rst                w_last;

    // one quotient bit per stage, one root bit in each of the first stages
    function automatic t_rst f_step(input t_rst p, input int k);
        t_rst                 q;
        logic [R2_BITS:0]     r;
        logic [SV_BITS-1:0]   v;
        logic [SREM_BITS-1:0] sr;
        logic [SREM_BITS-1:0] tr;
        int                   b;
        q = p;
        r = {p.rem, (k == 0)};
        if (r >= {1'b0, p.dv}) begin
            r     = r - {1'b0, p.dv};
            q.quo = {p.quo[DIV_BITS-2:0], 1'b1};
        end else begin
            q.quo = {p.quo[DIV_BITS-2:0], 1'b0};
        end
        q.rem = r[R2_BITS-1:0];
        if (k < SQRT_BITS) begin
            b  = SQRT_BITS - 1 - k;
            v  = SV_BITS'(p.dv);
            sr = {p.srem[SREM_BITS-3:0], v[2*b +: 2]};
            tr = SREM_BITS'({p.root, 2'b01});
            if (sr >= tr) begin
                q.srem = sr - tr;
                q.root = {p.root[SQRT_BITS-2:0], 1'b1};
            end else begin
                q.srem = sr;
                q.root = {p.root[SQRT_BITS-2:0], 1'b0};
            end
        end
        return q;
    endfunction

    always_comb begin
        w_seed      = '0;
        w_seed.side = i_geo.side;
        w_seed.dv   = i_geo.r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DIV_BITS-2:0], i_geo.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= f_step(w_seed, 0);
        for (int k = 1; k < DIV_BITS; k++) begin
            r_st[k] <= f_step(r_st[k-1], k);
        end
    end

    assign w_last = r_st[LAST];
    assign o_vld  = r_v[LAST];
    assign o_side = w_last.side;
    assign o_inv  = w_last.quo;
    assign o_root = w_last.root;

    a_div_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LAST] && w_last.dv != '0) |->
            ((PW'(w_last.quo) * PW'(w_last.dv) <= NUM) &&
             ((PW'(w_last.quo) + PW'(1)) * PW'(w_last.dv) > NUM)))
        else $error("reciprocal quotient out of range");

    a_sqrt_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |->
            ((PW'(w_last.root) * PW'(w_last.root) <= PW'(w_last.dv)) &&
             ((PW'(w_last.root) + PW'(1)) * (PW'(w_last.root) + PW'(1)) > PW'(w_last.dv))))
        else $error("square root not the floor root");

endmodule

@@ rtl/lennard_jones_pair_force.sv @@
// top level: lennard-jones pair force with minimum image, config registers and output stage
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------------
//  pair in   i_start, o_busy            i_atom_i_x/y/z, i_atom_j_x/y/z
//  result    o_done (one-cycle strobe)  o_force_x/y/z, o_energy_term, o_virial_term,
//                                       o_within_cutoff, o_coincident
//  config    i_cfg_valid, o_cfg_ready   i_cfg_index, i_cfg_data
//
// one pair per cycle; o_busy stays low and o_cfg_ready stays high
// the pipeline is 4 geometry stages, a 49-stage reciprocal divider
// (one quotient bit per stage), eight levels of two-stage multipliers with a register
// after s, and an output stage
// synchronous reset clears all valid bits and loads the default register values
// the receiver cannot stall, so nothing in the pipeline ever holds
module lennard_jones_pair_force import lj_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [POS_BITS-1:0]        i_atom_i_x,
    input  logic [POS_BITS-1:0]        i_atom_i_y,
    input  logic [POS_BITS-1:0]        i_atom_i_z,
    input  logic [POS_BITS-1:0]        i_atom_j_x,
    input  logic [POS_BITS-1:0]        i_atom_j_y,
    input  logic [POS_BITS-1:0]        i_atom_j_z,
    output logic                       o_done,
    output logic signed [FO_BITS-1:0]  o_force_x,
    output logic signed [FO_BITS-1:0]  o_force_y,
    output logic signed [FO_BITS-1:0]  o_force_z,
    output logic signed [FO_BITS-1:0]  o_energy_term,
    output logic signed [VO_BITS-1:0]  o_virial_term,
    output logic                       o_within_cutoff,
    output logic                       o_coincident,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [IDX_BITS-1:0]        i_cfg_index,
    input  logic [CFG_BITS-1:0]        i_cfg_data
);

    localparam int SD_DEPTH = 17;
    localparam int TAP_FX   = 12;
    localparam int TAP_V2   = 14;
    localparam int TAP_OUT  = 16;
    localparam int IV_DEPTH = 11;
    localparam int IV_L2    = 1;
    localparam int IV_L6    = 10;
    localparam int SG_DEPTH = 11;
    localparam int ED_DEPTH = 6;
    localparam int SW       = MW + 2;
    localparam logic signed [SW-1:0] F_HI = (SW'(1) <<< (FO_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] F_LO = -F_HI - SW'(1);
    localparam logic signed [SW-1:0] V_HI = (SW'(1) <<< (VO_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] V_LO = -V_HI - SW'(1);

    typedef struct packed {
        t_side                side;
        logic [SQRT_BITS-1:0] root;
    } t_late;

    function automatic logic signed [FO_BITS-1:0] f_sat_f(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > F_HI) ? F_HI : ((v < F_LO) ? F_LO : v);
        return c[FO_BITS-1:0];
    endfunction

    function automatic logic signed [VO_BITS-1:0] f_sat_v(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > V_HI) ? V_HI : ((v < V_LO) ? V_LO : v);
        return c[VO_BITS-1:0];
    endfunction

    function automatic logic signed [SW-1:0] f_signed(input logic [MW-1:0] m, input logic n);
        logic signed [SW-1:0] a;
        a = $signed({2'b00, m});
        return n ? -a : a;
    endfunction

    // configuration registers
    logic [2:0][POS_BITS-1:0]    r_box;
    logic [CFG_BITS-1:0]         r_sig6;
    logic [CFG_BITS-1:0]         r_eps24;
    logic [CFG_BITS-1:0]         r_eps4;
    logic [CFG_BITS-1:0]         r_cut;
    logic signed [CFG_BITS-1:0]  r_ecut;
    t_cfg_idx                    w_idx;

    assign w_idx       = t_cfg_idx'(i_cfg_index);
    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box   <= {BOX_RST, BOX_RST, BOX_RST};
            r_sig6  <= SIGMA6_RST;
            r_eps24 <= EPS24_RST;
            r_eps4  <= EPS4_RST;
            r_cut   <= CUT_RST;
            r_ecut  <= ECUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (w_idx)
                CFG_BOX_X:     r_box[0] <= i_cfg_data[POS_BITS-1:0];
                CFG_BOX_Y:     r_box[1] <= i_cfg_data[POS_BITS-1:0];
                CFG_BOX_Z:     r_box[2] <= i_cfg_data[POS_BITS-1:0];
                CFG_SIGMA6:    r_sig6   <= i_cfg_data;
                CFG_EPS24:     r_eps24  <= i_cfg_data;
                CFG_EPS4:      r_eps4   <= i_cfg_data;
                CFG_CUTOFF_SQ: r_cut    <= i_cfg_data;
                CFG_E_CUT:     r_ecut   <= $signed(i_cfg_data);
                default:       r_cut    <= r_cut;
            endcase
        end
    end

    // geometry and reciprocal
    t_geo                 w_geo;
    logic                 w_rvld;
    t_side                w_rside;
    logic [DIV_BITS-1:0]  w_inv;
    logic [SQRT_BITS-1:0] w_root;

    lj_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_start && !o_busy),
        .i_pos_i     ({i_atom_i_z, i_atom_i_y, i_atom_i_x}),
        .i_pos_j     ({i_atom_j_z, i_atom_j_y, i_atom_j_x}),
        .i_box       (r_box),
        .i_cutoff_sq (r_cut),
        .o_geo       (w_geo)
    );

    lj_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geo   (w_geo),
        .o_vld   (w_rvld),
        .o_side  (w_rside),
        .o_inv   (w_inv),
        .o_root  (w_root)
    );

    // delay lines that keep side data aligned with the multiplier chain
    logic [SD_DEPTH-1:0]  r_vd;
    t_late                r_sd [SD_DEPTH];
    logic [DIV_BITS-1:0]  r_iv [IV_DEPTH];
    logic [MW-1:0]        r_s7;
    logic [MW-1:0]        n_s7;
    logic [MW-1:0]        r_m2 [3];
    logic [MW-1:0]        r_m1 [3];
    logic [MW-1:0]        n_m2;
    logic [MW-1:0]        n_m1;
    logic [1:0]           r_sg [SG_DEPTH];
    logic [1:0]           n_sg;
    logic [MW-1:0]        r_ed [ED_DEPTH];
    logic [2:0][MW-1:0]   r_fd [2];

    logic [MW-1:0]        w_ma;
    logic [MW-1:0]        w_mb;
    logic [MW-1:0]        w_s;
    logic [MW-1:0]        w_p1;
    logic [MW-1:0]        w_e1;
    logic [MW-1:0]        w_p2;
    logic [MW-1:0]        w_em;
    logic [MW-1:0]        w_fm;
    logic [2:0][MW-1:0]   w_fx;
    logic [MW-1:0]        w_v1;
    logic [MW-1:0]        w_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else begin
            r_vd <= {r_vd[SD_DEPTH-2:0], w_rvld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= '{side: w_rside, root: w_root};
        for (int k = 1; k < SD_DEPTH; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
        r_iv[0] <= w_inv;
        for (int k = 1; k < IV_DEPTH; k++) begin
            r_iv[k] <= r_iv[k-1];
        end
        r_s7    <= n_s7;
        r_m2[0] <= n_m2;
        r_m2[1] <= r_m2[0];
        r_m2[2] <= r_m2[1];
        r_m1[0] <= n_m1;
        r_m1[1] <= r_m1[0];
        r_m1[2] <= r_m1[1];
        r_sg[0] <= n_sg;
        for (int k = 1; k < SG_DEPTH; k++) begin
            r_sg[k] <= r_sg[k-1];
        end
        r_ed[0] <= w_em;
        for (int k = 1; k < ED_DEPTH; k++) begin
            r_ed[k] <= r_ed[k-1];
        end
        r_fd[0] <= w_fx;
        r_fd[1] <= r_fd[0];
    end

    // s is known: signs and magnitudes of (2s - 1) and (s - 1)
    always_comb begin
        logic [MW-1:0] two_s;
        logic          fneg;
        logic          eneg;
        two_s = {w_s[MW-2:0], 1'b0};
        fneg  = two_s > ONE;
        eneg  = w_s < ONE;
        n_s7  = w_s;
        n_m2  = fneg ? two_s - ONE : ONE - two_s;
        n_m1  = eneg ? ONE - w_s : w_s - ONE;
        n_sg  = {eneg, fneg};
    end

    lj_mulq u_inv2  (.i_clk(i_clk), .i_a(MW'(w_inv)),       .i_b(MW'(w_inv)), .o_p(w_ma));
    lj_mulq u_inv3  (.i_clk(i_clk), .i_a(MW'(r_iv[IV_L2])), .i_b(w_ma),       .o_p(w_mb));
    lj_mulq u_s     (.i_clk(i_clk), .i_a(MW'(r_sig6)),      .i_b(w_mb),       .o_p(w_s));
    lj_mulq u_p1    (.i_clk(i_clk), .i_a(MW'(r_eps24)),     .i_b(r_s7),       .o_p(w_p1));
    lj_mulq u_e1    (.i_clk(i_clk), .i_a(MW'(r_eps4)),      .i_b(r_s7),       .o_p(w_e1));
    lj_mulq u_p2    (.i_clk(i_clk), .i_a(w_p1),             .i_b(r_m2[2]),    .o_p(w_p2));
    lj_mulq u_em    (.i_clk(i_clk), .i_a(w_e1),             .i_b(r_m1[2]),    .o_p(w_em));
    lj_mulq u_fm    (.i_clk(i_clk), .i_a(w_p2),          .i_b(MW'(r_iv[IV_L6])), .o_p(w_fm));
    lj_mulq u_v1    (.i_clk(i_clk), .i_a(w_fm),
                     .i_b(MW'(r_sd[TAP_FX].root)), .o_p(w_v1));
    lj_mulq u_v2    (.i_clk(i_clk), .i_a(w_v1),
                     .i_b(MW'(r_sd[TAP_V2].side.r2q)), .o_p(w_v2));

    for (genvar k = 0; k < 3; k++) begin : g_axis
        lj_mulq u_fx (
            .i_clk (i_clk),
            .i_a   (MW'(r_sd[TAP_FX].side.ad[k])),
            .i_b   (w_fm),
            .o_p   (w_fx[k])
        );
    end

    // output stage: signs, energy shift, saturation
    logic                       r_done;
    logic signed [FO_BITS-1:0]  r_fo [3];
    logic signed [FO_BITS-1:0]  r_eo;
    logic signed [VO_BITS-1:0]  r_vo;
    logic                       r_wo;
    logic                       r_co;
    logic signed [FO_BITS-1:0]  n_fo [3];
    logic signed [FO_BITS-1:0]  n_eo;
    logic signed [VO_BITS-1:0]  n_vo;
    t_side                      w_tap;

    assign w_tap = r_sd[TAP_OUT].side;

    always_comb begin
        logic                 live;
        logic                 fneg;
        logic                 eneg;
        logic signed [SW-1:0] e;
        live = w_tap.in_cut && !w_tap.coinc;
        fneg = r_sg[SG_DEPTH-1][0];
        eneg = r_sg[SG_DEPTH-1][1];
        for (int k = 0; k < 3; k++) begin
            n_fo[k] = live ? f_sat_f(f_signed(r_fd[1][k], w_tap.neg[k] ^ fneg)) : '0;
        end
        e    = f_signed(r_ed[ED_DEPTH-1], eneg) - SW'(r_ecut);
        n_eo = live ? f_sat_f(e) : '0;
        n_vo = live ? f_sat_v(f_signed(w_v2, fneg)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vd[TAP_OUT];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_fo[k] <= n_fo[k];
        end
        r_eo <= n_eo;
        r_vo <= n_vo;
        r_wo <= w_tap.in_cut;
        r_co <= w_tap.coinc;
    end

    assign o_done          = r_done;
    assign o_force_x       = r_fo[0];
    assign o_force_y       = r_fo[1];
    assign o_force_z       = r_fo[2];
    assign o_energy_term   = r_eo;
    assign o_virial_term   = r_vo;
    assign o_within_cutoff = r_wo;
    assign o_coincident    = r_co;

    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (!o_within_cutoff || o_coincident)) |->
            (o_force_x == '0 && o_force_y == '0 && o_force_z == '0 &&
             o_energy_term == '0 && o_virial_term == '0))
        else $error("nonzero terms outside cutoff or for coincident atoms");

endmodule

@@ test/tb_lennard_jones_pair_force.sv @@
// self-checking testbench of the lennard-jones pair force pipeline with a scoreboard class
module tb_lennard_jones_pair_force;
    import lj_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 90;
    localparam int PHASE_ITEMS = 360;

    typedef struct {
        logic signed [FO_BITS-1:0] force_x;
        logic signed [FO_BITS-1:0] force_y;
        logic signed [FO_BITS-1:0] force_z;
        logic signed [FO_BITS-1:0] energy;
        logic signed [VO_BITS-1:0] virial;
        logic                      in_cut;
        logic                      coinc;
    } t_pair_out;

    class pair_force_scoreboard;
        logic [POS_BITS-1:0]        box[3];
        logic [CFG_BITS-1:0]        sigma6, eps24, eps4, cut_sq;
        logic signed [CFG_BITS-1:0] e_cut;
        t_pair_out                  expected_q[$];
        int                         n_errors;

        function new();
            box = '{BOX_RST, BOX_RST, BOX_RST};
            sigma6 = SIGMA6_RST;
            eps24 = EPS24_RST;
            eps4 = EPS4_RST;
            cut_sq = CUT_RST;
            e_cut = ECUT_RST;
            n_errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_BITS-1:0] v);
            case (idx)
                CFG_BOX_X:     box[0] = v[POS_BITS-1:0];
                CFG_BOX_Y:     box[1] = v[POS_BITS-1:0];
                CFG_BOX_Z:     box[2] = v[POS_BITS-1:0];
                CFG_SIGMA6:    sigma6 = v;
                CFG_EPS24:     eps24 = v;
                CFG_EPS4:      eps4 = v;
                CFG_CUTOFF_SQ: cut_sq = v;
                CFG_E_CUT:     e_cut = v;
                default: ;
            endcase
        endfunction

        // fixed-point product of magnitudes, capped just below 2^62
        function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            if (p[127:64] != 0) return CAP;
            p = p >> FRAC_BITS;
            return (p > CAP) ? CAP : p[63:0];
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > v) bt = bt >> 2;
            while (bt != 0) begin
                if (v >= res + bt) begin
                    v = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            return res;
        endfunction

        function longint signed_mag(logic [63:0] mag, bit neg);
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function logic [63:0] clamp(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v;
        endfunction

        function t_pair_out pair_force(logic [5:0][POS_BITS-1:0] pos);
            t_pair_out  r;
            longint     d[3], l, fx[3], energy, virial;
            logic [63:0] ad[3], r2raw, inv, s, two_s, m2, fmag, m1, emag, rt, r2q;
            bit         fneg, eneg;
            r2raw = 0;
            fx = '{0, 0, 0};
            energy = 0;
            virial = 0;
            for (int k = 0; k < 3; k++) begin
                d[k] = longint'({40'd0, pos[k]}) - longint'({40'd0, pos[k+3]});
                l = longint'({40'd0, box[k]});
                if (2 * d[k] < -l) d[k] += l;
                else if (2 * d[k] > l) d[k] -= l;
                ad[k] = (d[k] < 0) ? -d[k] : d[k];
                r2raw += ad[k] * ad[k];
            end
            r.in_cut = r2raw < ({32'd0, cut_sq} << FRAC_BITS);
            r.coinc = (r2raw == 0);
            if (r.in_cut && !r.coinc) begin
                inv = (64'd1 << (3 * FRAC_BITS)) / r2raw;
                s = qmul(sigma6, qmul(inv, qmul(inv, inv)));
                two_s = 2 * s;
                fneg = two_s > ONE;
                m2 = fneg ? two_s - ONE : ONE - two_s;
                fmag = qmul(qmul(qmul(eps24, s), m2), inv);
                eneg = s < ONE;
                m1 = eneg ? ONE - s : s - ONE;
                emag = qmul(qmul(eps4, s), m1);
                rt = int_sqrt(r2raw);
                r2q = r2raw >> FRAC_BITS;
                for (int k = 0; k < 3; k++)
                    fx[k] = signed_mag(qmul(ad[k], fmag), (d[k] < 0) != fneg);
                energy = signed_mag(emag, eneg) - longint'(e_cut);
                virial = signed_mag(qmul(qmul(fmag, rt), r2q), fneg);
            end
            r.force_x = FO_BITS'(clamp(fx[0], FO_BITS));
            r.force_y = FO_BITS'(clamp(fx[1], FO_BITS));
            r.force_z = FO_BITS'(clamp(fx[2], FO_BITS));
            r.energy = FO_BITS'(clamp(energy, FO_BITS));
            r.virial = VO_BITS'(clamp(virial, VO_BITS));
            return r;
        endfunction

        function void note_pair(logic [5:0][POS_BITS-1:0] pos);
            expected_q.push_back(pair_force(pos));
        endfunction

        function void check_result(t_pair_out got);
            t_pair_out e;
            if (expected_q.size() == 0) begin
                $error("result with no pair outstanding");
                n_errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.force_x !== e.force_x) begin
                $error("force_x expected %0d got %0d", e.force_x, got.force_x);
                n_errors++;
            end
            if (got.force_y !== e.force_y) begin
                $error("force_y expected %0d got %0d", e.force_y, got.force_y);
                n_errors++;
            end
            if (got.force_z !== e.force_z) begin
                $error("force_z expected %0d got %0d", e.force_z, got.force_z);
                n_errors++;
            end
            if (got.energy !== e.energy) begin
                $error("energy_term expected %0d got %0d", e.energy, got.energy);
                n_errors++;
            end
            if (got.virial !== e.virial) begin
                $error("virial_term expected %0d got %0d", e.virial, got.virial);
                n_errors++;
            end
            if (got.in_cut !== e.in_cut) begin
                $error("within_cutoff expected %0d got %0d", e.in_cut, got.in_cut);
                n_errors++;
            end
            if (got.coinc !== e.coinc) begin
                $error("coincident expected %0d got %0d", e.coinc, got.coinc);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_start, o_busy, o_done;
    logic [POS_BITS-1:0] i_atom_i_x, i_atom_i_y, i_atom_i_z;
    logic [POS_BITS-1:0] i_atom_j_x, i_atom_j_y, i_atom_j_z;
    logic signed [FO_BITS-1:0] o_force_x, o_force_y, o_force_z, o_energy_term;
    logic signed [VO_BITS-1:0] o_virial_term;
    logic o_within_cutoff, o_coincident;
    logic i_cfg_valid, o_cfg_ready;
    logic [IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0] i_cfg_data;

    pair_force_scoreboard sb;
    int cycles;
    int burst_left;

    lennard_jones_pair_force i_dut (.*);

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // transaction monitor: config writes, accepted pairs and results
    always @(posedge i_clk) begin
        if (sb != null && i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_start && !o_busy)
                sb.note_pair({i_atom_j_z, i_atom_j_y, i_atom_j_x,
                              i_atom_i_z, i_atom_i_y, i_atom_i_x});
            if (o_done)
                sb.check_result('{o_force_x, o_force_y, o_force_z, o_energy_term,
                                  o_virial_term, o_within_cutoff, o_coincident});
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_BITS-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic cfg_all(logic [CFG_BITS-1:0] v[8]);
        for (int k = 0; k < 8; k++) cfg_write(t_cfg_idx'(k), v[k]);
    endtask

    // wait for the pipeline to empty before touching the registers
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pair(logic [5:0][POS_BITS-1:0] pos);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                i_start = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        {i_atom_j_z, i_atom_j_y, i_atom_j_x, i_atom_i_z, i_atom_i_y, i_atom_i_x} = pos;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic send_directed();
        logic [5:0][POS_BITS-1:0] p;
        logic [POS_BITS-1:0] h;
        h = sb.box[0] >> 1;
        send_pair('0);
        p = (6 * POS_BITS)'({$urandom, $urandom, $urandom});
        p[5:3] = p[2:0];
        send_pair(p);                                        // coincident, nonzero position
        send_pair({24'd0, 24'd0, 24'd65536, 72'd0});         // r of exactly one
        send_pair({24'd0, 24'd0, 24'd1, 72'd0});             // tiny distance saturates
        send_pair({24'd0, 24'd3, 24'd5, 72'd0});
        send_pair({72'd0, {3{24'hFFFFFF}}});
        send_pair({{3{24'hFFFFFF}}, 72'd0});
        send_pair({48'd0, 24'hFFFFFF, 48'd0, 24'd0});
        send_pair({72'd0, 48'd0, h});                        // half box, no fold
        send_pair({72'd0, 48'd0, h + 24'd1});                // just past half box
        send_pair({48'd0, h, 72'd0});
        send_pair({48'd0, h + 24'd1, 72'd0});
        send_pair({72'd0, 24'd0, h + 24'd1, 24'd0});
        send_pair({24'd0, h, 24'd0, 72'd0});
        send_pair({72'd0, h + 24'd1, 48'd0});
        send_pair({72'd0, 48'd0, 24'd163839});               // just inside the default cutoff
        send_pair({72'd0, 48'd0, 24'd163840});               // on the default cutoff
        send_pair({72'd0, 24'd70000, 24'd70000, 24'd70000});
        send_pair({24'd60000, 24'd1000, 24'd80000, 72'd0});
    endtask

    task automatic send_random(int n);
        logic [5:0][POS_BITS-1:0] p;
        int span;
        for (int k = 0; k < n; k++) begin
            p = (6 * POS_BITS)'({$urandom, $urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 9) < 7) begin
                // nearby pair so that more items land inside the cutoff
                case ($urandom_range(0, 2))
                    0: span = 256;
                    1: span = 140000;
                    default: span = 400000;
                endcase
                for (int a = 0; a < 3; a++)
                    p[a+3] = p[a] + POS_BITS'($urandom_range(0, 2 * span) - span);
            end
            send_pair(p);
        end
    endtask

    initial begin
        logic [CFG_BITS-1:0] v[8];
        sb = new();
        cycles = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        {i_atom_i_x, i_atom_i_y, i_atom_i_z, i_atom_j_x, i_atom_j_y, i_atom_j_z} = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_directed();
        send_random(PHASE_ITEMS);
        drain();

        v = '{$urandom_range(200000, 16777215), $urandom_range(200000, 16777215),
              $urandom_range(200000, 16777215), $urandom_range(1, 1 << 20),
              $urandom_range(1, 1 << 24), $urandom_range(1, 1 << 22),
              $urandom_range(65536, 1 << 22), $urandom};
        cfg_all(v);
        send_random(PHASE_ITEMS);
        drain();

        v = '{32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF};
        cfg_all(v);
        send_directed();
        send_random(PHASE_ITEMS);
        drain();

        // zero box lengths leave the difference unfolded
        v = '{0, 0, 0, 32'd65536, 32'd1572864, 32'd262144, 32'd409600, 32'h80000000};
        cfg_all(v);
        send_directed();
        send_random(PHASE_ITEMS / 2);
        drain();
        v = '{0, 0, 0, 0, 0, 0, 0, 0};
        cfg_all(v);
        send_random(PHASE_ITEMS / 2);
        drain();

        v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        cfg_all(v);
        send_random(PHASE_ITEMS);
        drain();

        if (sb.n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
